@@ rtl/rwr_pkg.sv @@
// shared types, constants and helper functions for the ray wall range block
package rwr_pkg;

    localparam int MAX_WALLS  = 64;
    localparam int ADDR_W     = $clog2(MAX_WALLS);
    localparam int CNT_W      = $clog2(MAX_WALLS + 1);
    localparam int DIV_STEPS  = 41;
    localparam int SQRT_STEPS = 25;

    // low 32 bits of one turn in radians, Q30 (upper part is exactly 2^32)
    localparam logic [31:0] TURN_LO  = 32'd2451551556;
    localparam logic [30:0] TRIG_ONE = 31'h4000_0000;
    localparam logic [13:0] OCT_HALF = 14'd8192;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CAST   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_MAX_RANGE = 2'd0,
        CFG_TOLERANCE = 2'd1,
        CFG_BIAS      = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
    } t_wall;

    typedef enum logic [5:0] {
        S_IDLE, S_XMUL, S_XREG, S_XSQ, S_HSTART, S_HT, S_HMUL, S_HDIV,
        S_SIN, S_COS, S_DIR, S_MDX, S_MDY, S_DXY, S_WALL, S_LOAD,
        S_DEN1, S_DEN2, S_NUM1, S_NUM2, S_NUMF, S_CHECK, S_PLO, S_PHI,
        S_PDIV, S_PQUO, S_BOX, S_SQ2, S_SQRT, S_DIST, S_DIV, S_DONE
    } t_state;

    // divisors of the taylor terms: sine 42 20 6, cosine 56 30 12
    function automatic logic [5:0] trig_div(input logic [2:0] sel);
        logic [5:0] k;
        unique case (sel)
            3'd0:    k = 6'd42;
            3'd1:    k = 6'd20;
            3'd2:    k = 6'd6;
            3'd3:    k = 6'd56;
            3'd4:    k = 6'd30;
            3'd5:    k = 6'd12;
            default: k = 6'd1;
        endcase
        return k;
    endfunction

    // point outside an interval widened by the slack on both sides
    function automatic logic outside(input logic signed [40:0] p,
                                     input logic [15:0] e,
                                     input logic signed [24:0] u,
                                     input logic signed [24:0] v);
        logic signed [42:0] p43;
        logic signed [42:0] e43;
        logic signed [42:0] lo;
        logic signed [42:0] hi;
        p43 = {{2{p[40]}}, p};
        e43 = $signed({27'd0, e});
        lo  = (u < v) ? {{18{u[24]}}, u} : {{18{v[24]}}, v};
        hi  = (u < v) ? {{18{v[24]}}, v} : {{18{u[24]}}, u};
        return ((p43 + e43) < lo) || ((p43 - e43) > hi);
    endfunction

endpackage

@@ rtl/ray_wall_range_top.sv @@
// ray wall range sensor: wall table, heading series, per-wall crossing on one serial unit
// clear, append and no-op raise o_done in the cycle after the request is taken
// cast: heading series, then each wall is loaded and tested, with a divide per axis and a
// square root for a crossing; one 41-step divide / 25-step root unit, one 33x33 multiplier
// busy stays high until o_done; one request at a time, o_done cannot be stalled
// synchronous active-low reset clears the wall count and restores the register defaults
module ray_wall_range_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic signed [23:0] i_wall_ax,
    input  logic signed [23:0] i_wall_ay,
    input  logic signed [23:0] i_wall_bx,
    input  logic signed [23:0] i_wall_by,
    input  logic signed [23:0] i_origin_x,
    input  logic signed [23:0] i_origin_y,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [23:0] o_range,
    output logic [6:0]         o_walls_held,
    output logic               o_dropped
);

    rwr_pkg::t_state r_state, n_state, r_ret, dv_ret;

    // configuration
    logic [22:0] r_max_range;
    logic [15:0] r_tol;
    logic [15:0] r_bias;

    // wall table
    rwr_pkg::t_wall r_mem [rwr_pkg::MAX_WALLS];
    rwr_pkg::t_wall r_rd;
    logic [rwr_pkg::CNT_W-1:0] r_cnt;
    logic [rwr_pkg::CNT_W-1:0] r_idx;
    logic mem_we;

    // cast state
    logic signed [23:0] r_ox, r_oy;
    logic [1:0]  r_quad;
    logic        r_swap;
    logic [13:0] r_red;
    logic [29:0] r_x, r_x2;
    logic [30:0] r_t, r_s, r_c;
    logic [2:0]  r_hsel;
    logic signed [31:0] r_cs, r_sn;
    logic signed [23:0] r_dx, r_dy;
    logic signed [24:0] r_ax, r_ay, r_bx, r_by, r_ex, r_ey;
    logic signed [49:0] r_den;
    logic signed [50:0] r_num;
    logic        r_axis;
    logic [49:0] r_pl;
    logic signed [40:0] r_px, r_py;
    logic [47:0] r_sq;
    logic signed [23:0] r_best;
    logic        r_drop;

    // shared multiplier
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic signed [65:0] r_prod;

    // shared divide / square-root unit
    logic [50:0] r_rem;
    logic [74:0] r_dvd;
    logic [49:0] r_dsr;
    logic [40:0] r_quo;
    logic [5:0]  r_it;
    logic        r_sqrt;
    logic        dv_load, dv_load_sqrt;
    logic [74:0] dv_dividend;
    logic [49:0] dv_divisor;
    logic [50:0] dv_sh, dv_sub;
    logic [51:0] dv_diff;
    logic        dv_ge;

    // derived values
    logic signed [23:0] d_axis;
    logic [23:0] d_mag;
    logic [50:0] num_mag;
    logic [49:0] den_mag;
    logic        neg_q;
    logic signed [40:0] q_signed;
    logic [46:0] x_sum;
    logic [30:0] s_c, c_c;
    logic signed [65:0] rnd;
    logic signed [26:0] hit_len;
    logic        box_out;
    logic        take;
    logic [13:0] ang_r;

    assign o_cfg_ready  = 1'b1;
    assign o_range      = r_best;
    assign o_walls_held = r_cnt;
    assign o_dropped    = r_drop;

    assign take  = start && !busy;
    assign ang_r = i_angle[13:0];

    assign m_p = m_a * m_b;

    assign d_axis   = r_axis ? r_dy : r_dx;
    assign d_mag    = d_axis[23] ? 24'(-d_axis) : 24'(d_axis);
    assign num_mag  = r_num[50] ? 51'(-r_num) : 51'(r_num);
    assign den_mag  = r_den[49] ? 50'(-r_den) : 50'(r_den);
    assign neg_q    = d_axis[23] ^ r_num[50] ^ r_den[49];
    assign q_signed = neg_q ? -$signed(r_quo) : $signed(r_quo);
    assign x_sum    = {1'b0, r_red, 32'd0} + 47'(r_prod[45:0]);
    assign s_c      = r_swap ? r_c : r_s;
    assign c_c      = r_swap ? r_s : r_c;
    assign rnd      = r_prod + 66'sd536870912;
    assign hit_len  = $signed({2'b00, r_quo[24:0]}) - $signed({11'd0, r_bias});

    assign box_out = rwr_pkg::outside(r_px, r_tol, 25'sd0, {r_dx[23], r_dx})
                  || rwr_pkg::outside(r_px, r_tol, r_ax, r_bx)
                  || rwr_pkg::outside(r_py, r_tol, 25'sd0, {r_dy[23], r_dy})
                  || rwr_pkg::outside(r_py, r_tol, r_ay, r_by);

    // serial step: restoring divide or one root digit
    assign dv_sh   = r_sqrt ? {r_rem[48:0], r_dvd[74:73]} : {r_rem[49:0], r_dvd[74]};
    assign dv_sub  = r_sqrt ? {24'd0, r_quo[24:0], 2'b01} : {1'b0, r_dsr};
    assign dv_diff = {1'b0, dv_sh} - {1'b0, dv_sub};
    assign dv_ge   = !dv_diff[51];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        busy         = 1'b1;
        o_done       = 1'b0;
        mem_we       = 1'b0;
        m_a          = '0;
        m_b          = '0;
        dv_load      = 1'b0;
        dv_load_sqrt = 1'b0;
        dv_dividend  = '0;
        dv_divisor   = '0;
        dv_ret       = rwr_pkg::S_IDLE;
        unique case (r_state)
            rwr_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (rwr_pkg::t_op'(i_op) == rwr_pkg::OP_CAST) begin
                        n_state = rwr_pkg::S_XMUL;
                    end else begin
                        n_state = rwr_pkg::S_DONE;
                    end
                    mem_we = (rwr_pkg::t_op'(i_op) == rwr_pkg::OP_APPEND)
                          && (r_cnt < rwr_pkg::CNT_W'(rwr_pkg::MAX_WALLS));
                end
            end
            rwr_pkg::S_XMUL: begin
                m_a = {19'd0, r_red};
                m_b = {1'b0, rwr_pkg::TURN_LO};
                n_state = rwr_pkg::S_XREG;
            end
            rwr_pkg::S_XREG: n_state = rwr_pkg::S_XSQ;
            rwr_pkg::S_XSQ: begin
                m_a = {3'd0, r_x};
                m_b = {3'd0, r_x};
                n_state = rwr_pkg::S_HSTART;
            end
            rwr_pkg::S_HSTART: begin
                dv_load     = 1'b1;
                dv_dividend = {45'd0, r_prod[59:30]};
                dv_divisor  = {44'd0, rwr_pkg::trig_div(3'd0)};
                dv_ret      = rwr_pkg::S_HT;
                n_state     = rwr_pkg::S_DIV;
            end
            rwr_pkg::S_HT: n_state = rwr_pkg::S_HMUL;
            rwr_pkg::S_HMUL: begin
                m_a = (r_hsel == 3'd2) ? {3'd0, r_x} : {3'd0, r_x2};
                m_b = {2'd0, r_t};
                priority if (r_hsel == 3'd2) begin
                    n_state = rwr_pkg::S_SIN;
                end else if (r_hsel == 3'd5) begin
                    n_state = rwr_pkg::S_COS;
                end else begin
                    n_state = rwr_pkg::S_HDIV;
                end
            end
            rwr_pkg::S_HDIV: begin
                dv_load     = 1'b1;
                dv_dividend = {45'd0, r_prod[59:30]};
                dv_divisor  = {44'd0, rwr_pkg::trig_div(r_hsel + 3'd1)};
                dv_ret      = rwr_pkg::S_HT;
                n_state     = rwr_pkg::S_DIV;
            end
            rwr_pkg::S_SIN: begin
                dv_load     = 1'b1;
                dv_dividend = {45'd0, r_x2};
                dv_divisor  = {44'd0, rwr_pkg::trig_div(3'd3)};
                dv_ret      = rwr_pkg::S_HT;
                n_state     = rwr_pkg::S_DIV;
            end
            rwr_pkg::S_COS: n_state = rwr_pkg::S_DIR;
            rwr_pkg::S_DIR: n_state = rwr_pkg::S_MDX;
            rwr_pkg::S_MDX: begin
                m_a = {r_cs[31], r_cs};
                m_b = {10'd0, r_max_range};
                n_state = rwr_pkg::S_MDY;
            end
            rwr_pkg::S_MDY: begin
                m_a = {r_sn[31], r_sn};
                m_b = {10'd0, r_max_range};
                n_state = rwr_pkg::S_DXY;
            end
            rwr_pkg::S_DXY: n_state = rwr_pkg::S_WALL;
            rwr_pkg::S_WALL: begin
                n_state = (r_idx == r_cnt) ? rwr_pkg::S_DONE : rwr_pkg::S_LOAD;
            end
            rwr_pkg::S_LOAD: n_state = rwr_pkg::S_DEN1;
            rwr_pkg::S_DEN1: begin
                m_a = {{9{r_dx[23]}}, r_dx};
                m_b = {{8{r_ey[24]}}, r_ey};
                n_state = rwr_pkg::S_DEN2;
            end
            rwr_pkg::S_DEN2: begin
                m_a = {{9{r_dy[23]}}, r_dy};
                m_b = {{8{r_ex[24]}}, r_ex};
                n_state = rwr_pkg::S_NUM1;
            end
            rwr_pkg::S_NUM1: begin
                m_a = {{8{r_ax[24]}}, r_ax};
                m_b = {{8{r_ey[24]}}, r_ey};
                n_state = rwr_pkg::S_NUM2;
            end
            rwr_pkg::S_NUM2: begin
                m_a = {{8{r_ay[24]}}, r_ay};
                m_b = {{8{r_ex[24]}}, r_ex};
                n_state = rwr_pkg::S_NUMF;
            end
            rwr_pkg::S_NUMF: n_state = rwr_pkg::S_CHECK;
            rwr_pkg::S_CHECK: begin
                // parallel lines, or a crossing far beyond the ray
                if (r_den == '0 || 50'(num_mag[50:17]) >= den_mag) begin
                    n_state = rwr_pkg::S_WALL;
                end else begin
                    n_state = rwr_pkg::S_PLO;
                end
            end
            rwr_pkg::S_PLO: begin
                m_a = {9'd0, d_mag};
                m_b = {7'd0, num_mag[25:0]};
                n_state = rwr_pkg::S_PHI;
            end
            rwr_pkg::S_PHI: begin
                m_a = {9'd0, d_mag};
                m_b = {8'd0, num_mag[50:26]};
                n_state = rwr_pkg::S_PDIV;
            end
            rwr_pkg::S_PDIV: begin
                dv_load     = 1'b1;
                dv_dividend = {r_prod[48:0], 26'd0} + {25'd0, r_pl};
                dv_divisor  = den_mag;
                dv_ret      = rwr_pkg::S_PQUO;
                n_state     = rwr_pkg::S_DIV;
            end
            rwr_pkg::S_PQUO: begin
                n_state = r_axis ? rwr_pkg::S_BOX : rwr_pkg::S_PLO;
            end
            rwr_pkg::S_BOX: begin
                m_a = {{7{r_px[25]}}, r_px[25:0]};
                m_b = {{7{r_px[25]}}, r_px[25:0]};
                n_state = box_out ? rwr_pkg::S_WALL : rwr_pkg::S_SQ2;
            end
            rwr_pkg::S_SQ2: begin
                m_a = {{7{r_py[25]}}, r_py[25:0]};
                m_b = {{7{r_py[25]}}, r_py[25:0]};
                n_state = rwr_pkg::S_SQRT;
            end
            rwr_pkg::S_SQRT: begin
                dv_load_sqrt = 1'b1;
                dv_dividend  = {1'b0, 49'({1'b0, r_sq} + {1'b0, r_prod[47:0]}), 25'd0};
                dv_ret       = rwr_pkg::S_DIST;
                n_state      = rwr_pkg::S_DIV;
            end
            rwr_pkg::S_DIST: n_state = rwr_pkg::S_WALL;
            rwr_pkg::S_DIV: begin
                n_state = (r_it == 6'd1) ? r_ret : rwr_pkg::S_DIV;
            end
            rwr_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = rwr_pkg::S_IDLE;
            end
        endcase
    end

    // configuration registers and wall count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range <= 23'd262144;
            r_tol       <= 16'd1311;
            r_bias      <= 16'd590;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (rwr_pkg::t_cfg_idx'(i_cfg_index))
                    rwr_pkg::CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                    rwr_pkg::CFG_TOLERANCE: r_tol       <= i_cfg_data[15:0];
                    rwr_pkg::CFG_BIAS:      r_bias      <= i_cfg_data[15:0];
                    rwr_pkg::CFG_UNUSED:    ;
                endcase
            end
            if (take && rwr_pkg::t_op'(i_op) == rwr_pkg::OP_CLEAR) begin
                r_cnt <= '0;
            end else if (mem_we) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // wall table, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[rwr_pkg::ADDR_W-1:0]] <= '{sx: i_wall_ax, sy: i_wall_ay,
                                                  ex: i_wall_bx, ey: i_wall_by};
        end
        r_rd <= r_mem[r_idx[rwr_pkg::ADDR_W-1:0]];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        if (dv_load) begin
            r_rem  <= {17'd0, dv_dividend[74:41]};
            r_dvd  <= {dv_dividend[40:0], 34'd0};
            r_dsr  <= dv_divisor;
            r_quo  <= '0;
            r_it   <= 6'(rwr_pkg::DIV_STEPS);
            r_sqrt <= 1'b0;
            r_ret  <= dv_ret;
        end else if (dv_load_sqrt) begin
            r_rem  <= '0;
            r_dvd  <= dv_dividend;
            r_quo  <= '0;
            r_it   <= 6'(rwr_pkg::SQRT_STEPS);
            r_sqrt <= 1'b1;
            r_ret  <= dv_ret;
        end else if (r_state == rwr_pkg::S_DIV) begin
            r_rem <= dv_ge ? dv_diff[50:0] : dv_sh;
            r_quo <= {r_quo[39:0], dv_ge};
            r_dvd <= r_sqrt ? {r_dvd[72:0], 2'b00} : {r_dvd[73:0], 1'b0};
            r_it  <= r_it - 6'd1;
        end

        unique case (r_state)
            rwr_pkg::S_IDLE: begin
                if (start) begin
                    r_best <= '0;
                    r_drop <= (rwr_pkg::t_op'(i_op) == rwr_pkg::OP_APPEND)
                           && (r_cnt >= rwr_pkg::CNT_W'(rwr_pkg::MAX_WALLS));
                    r_ox   <= i_origin_x;
                    r_oy   <= i_origin_y;
                    r_quad <= i_angle[15:14];
                    r_swap <= ang_r > rwr_pkg::OCT_HALF;
                    r_red  <= (ang_r > rwr_pkg::OCT_HALF) ? 14'(15'd16384 - {1'b0, ang_r})
                                                          : ang_r;
                    r_hsel <= 3'd0;
                end
            end
            rwr_pkg::S_XREG: r_x <= x_sum[45:16];
            rwr_pkg::S_HSTART: r_x2 <= r_prod[59:30];
            rwr_pkg::S_HT: r_t <= rwr_pkg::TRIG_ONE - r_quo[30:0];
            rwr_pkg::S_HDIV: r_hsel <= r_hsel + 3'd1;
            rwr_pkg::S_SIN: begin
                r_s    <= r_prod[60:30];
                r_hsel <= 3'd3;
            end
            rwr_pkg::S_COS: r_c <= rwr_pkg::TRIG_ONE - {2'b00, r_prod[59:31]};
            rwr_pkg::S_DIR: begin
                unique case (r_quad)
                    2'd0: begin
                        r_cs <= $signed({1'b0, c_c});
                        r_sn <= $signed({1'b0, s_c});
                    end
                    2'd1: begin
                        r_cs <= -$signed({1'b0, s_c});
                        r_sn <= $signed({1'b0, c_c});
                    end
                    2'd2: begin
                        r_cs <= -$signed({1'b0, c_c});
                        r_sn <= -$signed({1'b0, s_c});
                    end
                    2'd3: begin
                        r_cs <= $signed({1'b0, s_c});
                        r_sn <= -$signed({1'b0, c_c});
                    end
                endcase
            end
            rwr_pkg::S_MDY: r_dx <= rnd[53:30];
            rwr_pkg::S_DXY: begin
                r_dy   <= rnd[53:30];
                r_idx  <= '0;
                r_best <= $signed({1'b0, r_max_range});
            end
            rwr_pkg::S_LOAD: begin
                r_ax   <= 25'(r_rd.sx) - 25'(r_ox);
                r_ay   <= 25'(r_rd.sy) - 25'(r_oy);
                r_bx   <= 25'(r_rd.ex) - 25'(r_ox);
                r_by   <= 25'(r_rd.ey) - 25'(r_oy);
                r_ex   <= 25'(r_rd.ex) - 25'(r_rd.sx);
                r_ey   <= 25'(r_rd.ey) - 25'(r_rd.sy);
                r_axis <= 1'b0;
            end
            rwr_pkg::S_DEN2: r_den <= r_prod[49:0];
            rwr_pkg::S_NUM1: r_den <= r_den - r_prod[49:0];
            rwr_pkg::S_NUM2: r_num <= r_prod[50:0];
            rwr_pkg::S_NUMF: r_num <= r_num - r_prod[50:0];
            rwr_pkg::S_CHECK: begin
                if (r_den == '0 || 50'(num_mag[50:17]) >= den_mag) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            rwr_pkg::S_PHI: r_pl <= r_prod[49:0];
            rwr_pkg::S_PQUO: begin
                if (r_axis) begin
                    r_py <= q_signed;
                end else begin
                    r_px   <= q_signed;
                    r_axis <= 1'b1;
                end
            end
            rwr_pkg::S_BOX: begin
                if (box_out) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            rwr_pkg::S_SQ2: r_sq <= r_prod[47:0];
            rwr_pkg::S_DIST: begin
                if (hit_len < $signed({{3{r_best[23]}}, r_best})) begin
                    r_best <= hit_len[23:0];
                end
                r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a busy request");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= rwr_pkg::CNT_W'(rwr_pkg::MAX_WALLS))
        else $error("wall count beyond table size");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_dropped) |-> (o_walls_held == rwr_pkg::CNT_W'(rwr_pkg::MAX_WALLS)))
        else $error("append dropped with room in the table");
`endif

endmodule

@@ tb/rwr_checker.sv @@
// request monitor, wall range predictor and result comparison for the ray wall range block
`timescale 1ns / 100ps
module rwr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [22:0]        i_cfg_data,
    input  logic [1:0]         i_op,
    input  logic signed [23:0] i_wall_ax,
    input  logic signed [23:0] i_wall_ay,
    input  logic signed [23:0] i_wall_bx,
    input  logic signed [23:0] i_wall_by,
    input  logic signed [23:0] i_origin_x,
    input  logic signed [23:0] i_origin_y,
    input  logic [15:0]        i_angle,
    input  logic               o_done,
    input  logic signed [23:0] o_range,
    input  logic [6:0]         o_walls_held,
    input  logic               o_dropped,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [23:0] range;
        logic [6:0]         walls;
        logic               dropped;
    } t_answer;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned TURN_Q30 = 64'd6746518852;

    t_answer answer_q[$];

    longint unsigned ray_len;
    longint unsigned slack;
    longint unsigned bias;
    longint          wall_sx[rwr_pkg::MAX_WALLS];
    longint          wall_sy[rwr_pkg::MAX_WALLS];
    longint          wall_ex[rwr_pkg::MAX_WALLS];
    longint          wall_ey[rwr_pkg::MAX_WALLS];
    int              wall_cnt;
    int              mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = answer_q.size();

    function automatic void octant_sin_cos(input longint unsigned r,
                                           output longint unsigned s,
                                           output longint unsigned c);
        longint unsigned x, x2, t;
        x  = (r * TURN_Q30) >> 16;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        t  = ONE_Q30 - x2 / 56;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 12;
        c  = ONE_Q30 - ((x2 * t) >> 30) / 2;
    endfunction

    function automatic longint scale_div(input longint a, input longint b, input longint c);
        logic signed [127:0] pa, pb, pc, q;
        pa = a;
        pb = b;
        pc = c;
        q  = (pa * pb) / pc;
        return longint'(q[63:0]);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic bit off_span(input longint p, input longint e,
                                    input longint u, input longint v);
        longint lo, hi;
        lo = (u < v) ? u : v;
        hi = (u < v) ? v : u;
        return (p + e < lo) || (p - e > hi);
    endfunction

    function automatic longint nearest_hit(input longint ox, input longint oy,
                                           input logic [15:0] ang);
        longint unsigned s, c;
        longint cs, sn, dx, dy, best, eps;
        longint ax, ay, bx, by, ex, ey, den, num, px, py, hit_len;
        longint unsigned mn, md;
        if (ang[13:0] > rwr_pkg::OCT_HALF) octant_sin_cos(64'd16384 - ang[13:0], c, s);
        else octant_sin_cos(64'(ang[13:0]), s, c);
        case (ang[15:14])
            2'd0: begin cs = c; sn = s; end
            2'd1: begin cs = -longint'(s); sn = c; end
            2'd2: begin cs = -longint'(c); sn = -longint'(s); end
            default: begin cs = s; sn = -longint'(c); end
        endcase
        dx   = (cs * longint'(ray_len) + (64'sd1 <<< 29)) >>> 30;
        dy   = (sn * longint'(ray_len) + (64'sd1 <<< 29)) >>> 30;
        best = longint'(ray_len);
        eps  = longint'(slack);
        for (int i = 0; i < wall_cnt; i++) begin
            ax  = wall_sx[i] - ox;
            ay  = wall_sy[i] - oy;
            bx  = wall_ex[i] - ox;
            by  = wall_ey[i] - oy;
            ex  = bx - ax;
            ey  = by - ay;
            den = dx * ey - dy * ex;
            if (den == 0) continue;
            num = ax * ey - ay * ex;
            mn  = (num < 0) ? -num : num;
            md  = (den < 0) ? -den : den;
            // crossing too far along the ray to matter
            if ((mn >> 17) >= md) continue;
            px = scale_div(dx, num, den);
            py = scale_div(dy, num, den);
            if (off_span(px, eps, 0, dx) || off_span(px, eps, ax, bx) ||
                off_span(py, eps, 0, dy) || off_span(py, eps, ay, by)) continue;
            hit_len = longint'(int_sqrt(64'(px * px) + 64'(py * py))) - longint'(bias);
            if (hit_len < best) best = hit_len;
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        t_answer want, got;
        if (!i_rst_n) begin
            ray_len  = 262144;
            slack    = 1311;
            bias     = 590;
            wall_cnt = 0;
            mismatches = 0;
            answer_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (rwr_pkg::t_cfg_idx'(i_cfg_index))
                    rwr_pkg::CFG_MAX_RANGE: ray_len = i_cfg_data;
                    rwr_pkg::CFG_TOLERANCE: slack   = i_cfg_data[15:0];
                    rwr_pkg::CFG_BIAS:      bias    = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_done) begin
                got = '{o_range, o_walls_held, o_dropped};
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result range=%0d walls=%0d dropped=%0b",
                                 o_range, o_walls_held, o_dropped);
                end else begin
                    want = answer_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected range=%0d walls=%0d ",
                                     want.range, want.walls, "dropped=%0b, got %0d %0d %0b",
                                     want.dropped, got.range, got.walls, got.dropped);
                    end
                end
            end
            if (start && !busy) begin
                want = '0;
                case (rwr_pkg::t_op'(i_op))
                    rwr_pkg::OP_CLEAR: wall_cnt = 0;
                    rwr_pkg::OP_APPEND: begin
                        if (wall_cnt < rwr_pkg::MAX_WALLS) begin
                            wall_sx[wall_cnt] = i_wall_ax;
                            wall_sy[wall_cnt] = i_wall_ay;
                            wall_ex[wall_cnt] = i_wall_bx;
                            wall_ey[wall_cnt] = i_wall_by;
                            wall_cnt++;
                        end else begin
                            want.dropped = 1'b1;
                        end
                    end
                    rwr_pkg::OP_CAST:
                        want.range = 24'(nearest_hit(i_origin_x, i_origin_y, i_angle));
                    default: ;
                endcase
                want.walls = 7'(wall_cnt);
                answer_q = {answer_q, want};
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
// stimulus, clock, reset and verdict for the ray wall range testbench
`timescale 1ns / 100ps
module tb_top;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [22:0]        i_cfg_data = '0;
    logic [1:0]         i_op = '0;
    logic signed [23:0] i_wall_ax = '0;
    logic signed [23:0] i_wall_ay = '0;
    logic signed [23:0] i_wall_bx = '0;
    logic signed [23:0] i_wall_by = '0;
    logic signed [23:0] i_origin_x = '0;
    logic signed [23:0] i_origin_y = '0;
    logic [15:0]        i_angle = '0;
    logic               o_done;
    logic signed [23:0] o_range;
    logic [6:0]         o_walls_held;
    logic               o_dropped;
    int                 fail_count;
    int                 pending;

    int idle_pct;
    int cycle_cnt;
    int cast_cnt;
    int append_cnt;
    int other_cnt;
    int cfg_cnt;

    localparam int CYCLE_LIMIT = 20000000;

    always #1 i_clk = ~i_clk;

    ray_wall_range_top uut (.*);

    rwr_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_valid, .o_cfg_ready, .i_cfg_index,
        .i_cfg_data, .i_op, .i_wall_ax, .i_wall_ay, .i_wall_bx, .i_wall_by,
        .i_origin_x, .i_origin_y, .i_angle, .o_done, .o_range, .o_walls_held,
        .o_dropped, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [23:0] rand24();
        return 24'($urandom);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // one request; returns after the edge that took it, and after an idle wait with start low if one is drawn
    task automatic send_request(input rwr_pkg::t_op op, input logic [23:0] ax,
                                input logic [23:0] ay,
                                input logic [23:0] bx, input logic [23:0] by,
                                input logic [23:0] ox, input logic [23:0] oy,
                                input logic [15:0] ang);
        start      <= 1'b1;
        i_op       <= op;
        i_wall_ax  <= ax;
        i_wall_ay  <= ay;
        i_wall_bx  <= bx;
        i_wall_by  <= by;
        i_origin_x <= ox;
        i_origin_y <= oy;
        i_angle    <= ang;
        do @(posedge i_clk); while (busy);
        case (op)
            rwr_pkg::OP_CAST:   cast_cnt++;
            rwr_pkg::OP_APPEND: append_cnt++;
            default:            other_cnt++;
        endcase
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input rwr_pkg::t_cfg_idx idx, input logic [22:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_cnt++;
    endtask

    function automatic logic [23:0] near_coord();
        return 24'($signed($urandom_range(0, 655360)) - 327680);
    endfunction

    task automatic add_wall();
        logic [23:0] ax, ay;
        ax = near_coord();
        ay = near_coord();
        case ($urandom_range(3))
            0: send_request(rwr_pkg::OP_APPEND, ax, ay, ax, near_coord(),
                            rand24(), rand24(), rand16());
            1: send_request(rwr_pkg::OP_APPEND, ax, ay, near_coord(), ay,
                            rand24(), rand24(), rand16());
            default: send_request(rwr_pkg::OP_APPEND, ax, ay, near_coord(), near_coord(),
                                  rand24(), rand24(), rand16());
        endcase
    endtask

    task automatic cast_ray();
        send_request(rwr_pkg::OP_CAST, rand24(), rand24(), rand24(), rand24(),
                     24'($signed($urandom_range(0, 262144)) - 131072),
                     24'($signed($urandom_range(0, 262144)) - 131072), rand16());
    endtask

    initial begin
        int n;
        cycle_cnt = 0;
        cast_cnt = 0;
        append_cnt = 0;
        other_cnt = 0;
        cfg_cnt = 0;
        idle_pct = 21;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(rwr_pkg::CFG_MAX_RANGE, 23'd262144);
        write_reg(rwr_pkg::CFG_TOLERANCE, 23'd1311);
        write_reg(rwr_pkg::CFG_BIAS, 23'd590);
        write_reg(rwr_pkg::CFG_UNUSED, 23'h7FFFFF);

        // directed: empty table, wall shapes, axis and octant headings, extremes
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd0);
        send_request(rwr_pkg::OP_APPEND, 24'sd65536, -24'sd65536, 24'sd65536, 24'sd65536,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_APPEND, -24'sd65536, 24'sd131072, 24'sd65536, 24'sd131072,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_APPEND, 24'sd30000, 24'sd30000, 24'sd30000, 24'sd30000,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_APPEND, 24'sd0, 24'sd10000, 24'sd200000, 24'sd10000,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_APPEND, -24'sd100000, -24'sd50000, -24'sd50000,
                     -24'sd100000, '0, '0, '0);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd0);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd16384);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd32768);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd49152);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd8192);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd8193);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd40960);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, 24'sd5000, -24'sd5000, 16'hFFFF);
        send_request(rwr_pkg::OP_APPEND, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, 24'h7FFFFF, 24'h800000, 16'd24576);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, 24'h800000, 24'h7FFFFF, 16'd57344);
        send_request(rwr_pkg::OP_NOP, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                     24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
        send_request(rwr_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd1000);
        drain();
        // zero ray length: no hit possible
        write_reg(rwr_pkg::CFG_MAX_RANGE, 23'd0);
        send_request(rwr_pkg::OP_APPEND, 24'sd65536, -24'sd65536, 24'sd65536, 24'sd65536,
                     '0, '0, '0);
        send_request(rwr_pkg::OP_CAST, '0, '0, '0, '0, '0, '0, 16'd0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 21 : (phase == 1) ? 85 : 0;
            case (phase)
                0: begin
                    write_reg(rwr_pkg::CFG_MAX_RANGE, 23'd262144);
                    write_reg(rwr_pkg::CFG_TOLERANCE, 23'd0);
                    write_reg(rwr_pkg::CFG_BIAS, 23'd65535);
                end
                1: begin
                    write_reg(rwr_pkg::CFG_MAX_RANGE, 23'h7FFFFF);
                    write_reg(rwr_pkg::CFG_TOLERANCE, 23'd65535);
                    write_reg(rwr_pkg::CFG_BIAS, 23'd0);
                end
                default: begin
                    write_reg(rwr_pkg::CFG_MAX_RANGE, 23'($urandom_range(65536, 1048576)));
                    write_reg(rwr_pkg::CFG_TOLERANCE, 23'($urandom_range(65535)));
                    write_reg(rwr_pkg::CFG_BIAS, 23'($urandom_range(2000)));
                end
            endcase
            n = 0;
            if (phase == 1) begin
                // fill the table past capacity, then cast over the full table
                send_request(rwr_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
                repeat (rwr_pkg::MAX_WALLS + 2) add_wall();
                cast_ray();
                cast_ray();
                // sender holds off until everything is answered
                drain();
                n += rwr_pkg::MAX_WALLS + 5;
            end
            while (n < 190) begin
                if ($urandom_range(9) < 8) begin
                    if ($urandom_range(2) == 0) begin
                        send_request(rwr_pkg::OP_CLEAR, rand24(), rand24(), rand24(), rand24(),
                                     rand24(), rand24(), rand16());
                        n++;
                    end
                    repeat ($urandom_range(1, 6)) begin
                        add_wall();
                        n++;
                    end
                    repeat ($urandom_range(1, 4)) begin
                        cast_ray();
                        n++;
                    end
                end else begin
                    // noise: full-range fields and any op
                    send_request(rwr_pkg::t_op'($urandom_range(3)), rand24(), rand24(),
                                 rand24(), rand24(), rand24(), rand24(), rand16());
                    n++;
                end
            end
            drain();
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("covered %0d casts, %0d appends, %0d clear/no-op requests, %0d register writes",
                 cast_cnt, append_cnt, other_cnt, cfg_cnt);
        $display("sender idle rates 21, 85 and 0 percent over three register settings");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rwr_pkg.sv
rtl/ray_wall_range_top.sv
tb/rwr_checker.sv
tb/tb_top.sv
